// ===== src/mqpw_pkg.sv =====
// package for the message queue with priority waiters
// holds transaction types, action and status codes, sizing constants
package mqpw_pkg;

    localparam int SLOT_DEPTH   = 16;
    localparam int WAITER_DEPTH = 8;
    localparam int MESSAGE_BITS = 32;
    localparam int SLOT_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CNT_W        = $clog2(SLOT_DEPTH + 1);
    localparam int WIDX_W       = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WCNT_W       = $clog2(WAITER_DEPTH + 1);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_JAM  = 2'd1;
    localparam logic [1:0] ACT_RECV = 2'd2;
    localparam logic [1:0] ACT_BAD  = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;
    localparam logic [1:0] ST_WFULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] message;
        logic        blocking;
        logic [7:0]  thread_id;
        logic [7:0]  thread_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] message_out;
        logic        wake_valid;
        logic [7:0]  wake_thread_id;
        logic        preempt;
        logic [4:0]  fill_level;
    } rsp_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } waiter_t;

endpackage

// ===== src/message_queue_with_priority_waiters.sv =====
// top level of the message queue with priority waiters
// depends on mqpw_pkg, mqpw_front, mqpw_back
//
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     req_t
// out       output     out_valid / out_stall   rsp_t
// cfg       input      cfg_valid / cfg_ready   capacity, 5 bits
//
// a request's response follows its idle lookahead and exec states;
// a successful receive adds a slot read state after exec
// the back end starts the next request only once out is empty, so each
// transaction runs through its states and any out_stall cycles first
// two front queue entries let requests arrive while the back end works
// a capacity write empties the ring, both waiter lists and the front queue
// rst_n clears all control state; stored messages and waiters are not reset
module message_queue_with_priority_waiters
    import mqpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data
);

    logic q_valid, q_pop, cfg_wr;
    req_t q_req;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    mqpw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_wr),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    mqpw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_wr),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_data)
    );

endmodule

// ===== src/mqpw_front.sv =====
// front end: takes request transactions, masks the message, queues them
// depends on mqpw_pkg
module mqpw_front
    import mqpw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic flush,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_req,
    output logic q_valid,
    input  logic q_pop,
    output req_t q_req
);

    localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    req_t            buf_reg [QUEUE_DEPTH];
    logic [QI_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            push;
    req_t            clean;

    assign in_stall = (cnt_reg == QC_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = buf_reg[rd_reg];

    always_comb
    begin
        clean = in_req;
        clean.message = in_req.message & 32'((64'd1 << MESSAGE_BITS) - 64'd1);
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push)
        begin
            wr_next = (wr_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_next = (rd_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg + QC_W'(push) - QC_W'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= clean;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (flush)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/mqpw_waiters.sv =====
// sorted waiter list: registered sorted insert and head pop over a register row
// depends on mqpw_pkg
module mqpw_waiters
    import mqpw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              ins,
    input  waiter_t           ins_w,
    input  logic              pop,
    output waiter_t           head,
    output logic [WCNT_W-1:0] count
);

    waiter_t           row_reg [WAITER_DEPTH];
    logic [WCNT_W-1:0] cnt_reg;
    logic [WAITER_DEPTH-1:0] after;

    assign head  = row_reg[0];
    assign count = cnt_reg;

    always_comb
    begin
        for (int i = 0; i < WAITER_DEPTH; i++)
        begin
            after[i] = (WCNT_W'(i) < cnt_reg) && (row_reg[i].prio > ins_w.prio);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WAITER_DEPTH; i++)
        begin
            if (ins)
            begin
                if (!after[i])
                begin
                    if (i == 0 || after[(i > 0) ? i - 1 : 0])
                    begin
                        row_reg[i] <= ins_w;
                    end
                    else
                    begin
                        row_reg[i] <= row_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            else if (pop && i < WAITER_DEPTH - 1)
            begin
                row_reg[i] <= row_reg[(i < WAITER_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            cnt_reg <= '0;
        end
        else if (ins)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== src/mqpw_back.sv =====
// back end: carries out one request at a time against the ring and waiter lists
// depends on mqpw_pkg and mqpw_waiters
module mqpw_back
    import mqpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [4:0] cfg_data,
    input  logic       q_valid,
    output logic       q_pop,
    input  req_t       q_req,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [MESSAGE_BITS-1:0] slots [SLOT_DEPTH];
    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [MESSAGE_BITS-1:0] rd_data_reg;
    rsp_t              rsp_reg, rsp_next;
    logic              ov_reg, ov_next;
    logic [SLOT_W-1:0] wslot;
    logic              wr_en;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W-1:0]  h_ext, cap_m1;
    logic              s_ins, s_pop, r_ins, r_pop;
    waiter_t           s_head, r_head, me;
    logic [WCNT_W-1:0] s_cnt, r_cnt;
    logic [CNT_W-1:0]  cfg_cap;

    assign me      = '{id: q_req.thread_id, prio: q_req.thread_priority};
    assign h_ext   = CNT_W'(head_reg);
    assign cap_m1  = cap_reg - 1'b1;
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;

    always_comb
    begin
        if (cfg_data == 5'd0)
        begin
            cfg_cap = CNT_W'(1);
        end
        else if (32'(cfg_data) > SLOT_DEPTH)
        begin
            cfg_cap = CNT_W'(SLOT_DEPTH);
        end
        else
        begin
            cfg_cap = CNT_W'(cfg_data);
        end
    end

    mqpw_waiters u_send (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_valid),
        .ins   (s_ins),
        .ins_w (me),
        .pop   (s_pop),
        .head  (s_head),
        .count (s_cnt)
    );

    mqpw_waiters u_recv (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_valid),
        .ins   (r_ins),
        .ins_w (me),
        .pop   (r_pop),
        .head  (r_head),
        .count (r_cnt)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        ov_next    = ov_reg && out_stall;
        q_pop      = 1'b0;
        s_ins      = 1'b0;
        s_pop      = 1'b0;
        r_ins      = 1'b0;
        r_pop      = 1'b0;
        wr_en      = 1'b0;
        wslot      = head_reg;
        tail_sum   = {1'b0, h_ext} + {1'b0, cnt_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                q_pop    = 1'b1;
                rsp_next = '0;
                rsp_next.fill_level = 5'(cnt_reg);
                state_next = S_IDLE;
                ov_next  = 1'b1;
                case (q_req.action) inside
                    ACT_SEND, ACT_JAM:
                    begin
                        if (cnt_reg >= cap_reg)
                        begin
                            if (!q_req.blocking)
                            begin
                                rsp_next.status = ST_FAIL;
                            end
                            else if (s_cnt == WCNT_W'(WAITER_DEPTH))
                            begin
                                rsp_next.status = ST_WFULL;
                            end
                            else
                            begin
                                rsp_next.status = ST_QUEUED;
                                s_ins = 1'b1;
                            end
                        end
                        else
                        begin
                            if (q_req.action == ACT_JAM)
                            begin
                                wslot = (head_reg == '0) ? SLOT_W'(cap_m1) : head_reg - 1'b1;
                                head_next = wslot;
                            end
                            else
                            begin
                                if (tail_sum >= {1'b0, cap_reg})
                                begin
                                    tail_sum = tail_sum - {1'b0, cap_reg};
                                end
                                wslot = SLOT_W'(tail_sum);
                            end
                            wr_en = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            rsp_next.fill_level = 5'(cnt_reg + 1'b1);
                            if (r_cnt != '0)
                            begin
                                r_pop = 1'b1;
                                rsp_next.wake_valid = 1'b1;
                                rsp_next.wake_thread_id = r_head.id;
                                rsp_next.preempt = r_head.prio > q_req.thread_priority;
                            end
                        end
                    end
                    ACT_RECV:
                    begin
                        if (cnt_reg == '0)
                        begin
                            if (!q_req.blocking)
                            begin
                                rsp_next.status = ST_FAIL;
                            end
                            else if (r_cnt == WCNT_W'(WAITER_DEPTH))
                            begin
                                rsp_next.status = ST_WFULL;
                            end
                            else
                            begin
                                rsp_next.status = ST_QUEUED;
                                r_ins = 1'b1;
                            end
                        end
                        else
                        begin
                            ov_next    = 1'b0;
                            state_next = S_READ;
                            head_next  = (h_ext == cap_m1) ? '0 : head_reg + 1'b1;
                            cnt_next   = cnt_reg - 1'b1;
                            rsp_next.fill_level = 5'(cnt_reg - 1'b1);
                            if (s_cnt != '0)
                            begin
                                s_pop = 1'b1;
                                rsp_next.wake_valid = 1'b1;
                                rsp_next.wake_thread_id = s_head.id;
                                rsp_next.preempt = s_head.prio > q_req.thread_priority;
                            end
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_FAIL;
                    end
                endcase
            end
            S_READ:
            begin
                rsp_next.message_out = 32'(rd_data_reg);
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wslot] <= q_req.message[MESSAGE_BITS-1:0];
        end
        rd_data_reg <= slots[head_reg];
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            cap_reg   <= CNT_W'(SLOT_DEPTH);
            ov_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            cap_reg   <= cfg_cap;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== tb/sv/tb_message_queue_with_priority_waiters.sv =====
// testbench for message_queue_with_priority_waiters
// drives requests and capacity writes, checks every response against a mailbox predictor
// depends on mqpw_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_message_queue_with_priority_waiters;
    import mqpw_pkg::*;

    class mailbox_scoreboard;
        logic [31:0] slots [SLOT_DEPTH];
        int unsigned head;
        int unsigned count;
        int unsigned cap;
        waiter_t send_w [$];
        waiter_t recv_w [$];
        rsp_t pending_rsp [$];
        int mismatches;

        function void create(int unsigned value);
            cap = (value < 1) ? 1 : ((value > SLOT_DEPTH) ? SLOT_DEPTH : value);
            head = 0;
            count = 0;
            send_w.delete();
            recv_w.delete();
        endfunction

        function logic [1:0] enqueue_waiter(ref waiter_t wl [$], input req_t r);
            int pos;
            waiter_t w;
            if (wl.size() >= WAITER_DEPTH)
                return ST_WFULL;
            pos = 0;
            while (pos < wl.size() && wl[pos].prio > r.thread_priority)
                pos++;
            w.id = r.thread_id;
            w.prio = r.thread_priority;
            wl.insert(pos, w);
            return ST_QUEUED;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            waiter_t w;
            bit popped;
            int unsigned slot;
            e = '0;
            popped = 0;
            if (r.action == ACT_BAD)
            begin
                e.status = ST_FAIL;
            end
            else if (r.action == ACT_SEND || r.action == ACT_JAM)
            begin
                if (count >= cap)
                begin
                    e.status = r.blocking ? enqueue_waiter(send_w, r) : ST_FAIL;
                end
                else
                begin
                    if (r.action == ACT_JAM)
                    begin
                        head = (head % cap + cap - 1) % cap;
                        slot = head;
                    end
                    else
                    begin
                        slot = (head + count) % cap;
                    end
                    slots[slot] = r.message;
                    count++;
                    if (recv_w.size() > 0)
                    begin
                        w = recv_w.pop_front();
                        popped = 1;
                    end
                end
            end
            else
            begin
                if (count == 0)
                begin
                    e.status = r.blocking ? enqueue_waiter(recv_w, r) : ST_FAIL;
                end
                else
                begin
                    slot = head % cap;
                    e.message_out = slots[slot];
                    head = (slot + 1) % cap;
                    count--;
                    if (send_w.size() > 0)
                    begin
                        w = send_w.pop_front();
                        popped = 1;
                    end
                end
            end
            if (popped)
            begin
                e.wake_valid = 1'b1;
                e.wake_thread_id = w.id;
                e.preempt = w.prio > r.thread_priority;
            end
            e.fill_level = count[4:0];
            pending_rsp.push_back(e);
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", a);
                return;
            end
            e = pending_rsp.pop_front();
            if (a.status !== e.status || a.message_out !== e.message_out
                || a.wake_valid !== e.wake_valid || a.wake_thread_id !== e.wake_thread_id
                || a.preempt !== e.preempt || a.fill_level !== e.fill_level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response mismatch: expected st=%0d msg=%h wv=%0d wid=%0d",
                              " pre=%0d fill=%0d, actual st=%0d msg=%h wv=%0d wid=%0d",
                              " pre=%0d fill=%0d"},
                        e.status, e.message_out, e.wake_valid, e.wake_thread_id,
                        e.preempt, e.fill_level, a.status, a.message_out,
                        a.wake_valid, a.wake_thread_id, a.preempt, a.fill_level);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [4:0] cfg_data;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;

    mailbox_scoreboard mbox_sb;
    int cycle_count;
    int hold_cycles;
    bit stall_random;

    message_queue_with_priority_waiters i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("message_queue_with_priority_waiters: mismatch");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                mbox_sb.check_response(out_data);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (stall_random && out_valid && !out_stall)
            begin
                gap = $urandom_range(0, 14);
                out_stall <= (gap > 0);
                if (gap > 1)
                    hold_cycles = gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_capacity(input logic [4:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mbox_sb.create(value);
    endtask

    task automatic send_request(input req_t r, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        mbox_sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mbox_sb.pending_rsp.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] act, bit blk);
        req_t r;
        r.action = act;
        r.message = $urandom();
        r.blocking = blk;
        r.thread_id = 8'($urandom_range(0, 255));
        r.thread_priority = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 3));
        return r;
    endfunction

    initial
    begin
        req_t r;
        int phase;
        int n;
        int caps [6] = '{16, 1, 0, 3, 31, 7};
        mbox_sb = new();
        mbox_sb.create(16);
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        hold_cycles = 0;
        stall_random = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every action, full/empty, waiter overflow
        r = '0; r.action = ACT_RECV; send_request(r, 0);
        r.blocking = 1'b1; send_request(r, 0);
        r.action = ACT_BAD; r.message = '1; send_request(r, 0);
        r = '1; r.action = ACT_SEND; send_request(r, 0);
        r.action = ACT_JAM; r.message = 32'h0; send_request(r, 0);
        r.action = ACT_RECV; r.thread_priority = 8'h00; send_request(r, 0);
        send_request(r, 0);
        drain();
        write_capacity(5'd1);
        r = make_req(ACT_SEND, 0); send_request(r, 0);
        r = make_req(ACT_JAM, 0); send_request(r, 0);
        for (int i = 0; i < 9; i++)
        begin
            r = make_req(ACT_SEND, 1); send_request(r, 0);
        end
        r = make_req(ACT_RECV, 0); r.thread_priority = 0; send_request(r, 0);
        r = make_req(ACT_RECV, 0); r.thread_priority = 8'hff; send_request(r, 0);
        drain();

        stall_random = 1'b1;
        for (phase = 0; phase < 6; phase++)
        begin
            write_capacity(caps[phase][4:0]);
            if (phase == 3)
                hold_cycles = 200;
            for (n = 0; n < 175; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    r = make_req(ACT_BAD, 1'($urandom_range(0, 1)));
                else
                    r = make_req($urandom_range(0, 5) < 3 ? ACT_SEND
                                 : ($urandom_range(0, 3) == 0 ? ACT_JAM : ACT_RECV),
                                 1'($urandom_range(0, 1)));
                if (n % 40 > 30)
                    r.action = ACT_RECV;
                send_request(r, (n % 50) < 35 && phase != 3);
            end
            drain();
        end

        if (mbox_sb.mismatches == 0 && mbox_sb.pending_rsp.size() == 0)
            $display("message_queue_with_priority_waiters: match");
        else
            $display("message_queue_with_priority_waiters: mismatch");
        $finish;
    end
endmodule
